@@ design/u7d_pkg.sv @@
package u7d_pkg;

  // Byte codes used by the decoder
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [4:0]  UNIT_BITS = 5'd16;
  localparam logic [4:0]  B64_BITS  = 5'd6;

  // Decoder mode, one-hot
  typedef enum logic [2:0] {
    MODE_DIRECT = 3'b001,
    MODE_PLUS   = 3'b010,
    MODE_B64    = 3'b100
  } mode_e;

  // Error kind carried on each result
  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_BYTE = 2'd1,
    ERR_SURR = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [20:0] char_val;
    logic        has_char;
    logic [1:0]  error_kind;
    logic        stream_end;
  } result_t;

  // Base64 alphabet lookup: {hit, 6-bit value}
  function automatic logic [6:0] b64_lookup(input logic [7:0] b);
    logic [7:0] off;
    off = 8'd0;
    b64_lookup = 7'd0;
    if (b >= 8'h41 && b <= 8'h5A) begin
      off = b - 8'h41;
      b64_lookup = {1'b1, off[5:0]};
    end else if (b >= 8'h61 && b <= 8'h7A) begin
      off = b - 8'h61 + 8'd26;
      b64_lookup = {1'b1, off[5:0]};
    end else if (b >= 8'h30 && b <= 8'h39) begin
      off = b - 8'h30 + 8'd52;
      b64_lookup = {1'b1, off[5:0]};
    end else if (b == CH_PLUS) begin
      b64_lookup = {1'b1, 6'd62};
    end else if (b == CH_SLASH) begin
      b64_lookup = {1'b1, 6'd63};
    end
  endfunction

  // Bytes that stand for themselves outside a base64 run
  function automatic logic is_direct(input logic [7:0] b);
    is_direct = (b == CH_LF) || (b == CH_CR) ||
                ((b >= CH_SPACE) && (b < CH_DEL) && (b != CH_PLUS) &&
                 (b != CH_TILDE) && (b != CH_BSLASH));
  endfunction

endpackage

@@ design/u7d_byte_if.sv @@
interface u7d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

@@ design/u7d_cp_if.sv @@
interface u7d_cp_if;
  logic        valid;
  logic        ready;
  logic [20:0] char_val;
  logic        has_char;
  logic [1:0]  error_kind;
  logic        stream_end;

  modport source (output valid, output char_val, output has_char,
                  output error_kind, output stream_end, input ready);
  modport sink   (input valid, input char_val, input has_char,
                  input error_kind, input stream_end, output ready);
endinterface

@@ design/u7d_in_stage.sv @@
module u7d_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  u7d_byte_if.sink        byte_i,
  input  logic            take_i,
  output logic            item_valid_o,
  output u7d_pkg::item_t  item_o
);

  logic           valid_q;
  u7d_pkg::item_t item_q;
  logic           load;

  // Take a new request when empty or when the held item moves on
  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.in_byte <= byte_i.in_byte;
      item_q.is_last <= byte_i.is_last;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ design/u7d_step.sv @@
module u7d_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  u7d_pkg::item_t    item_i,
  input  logic              out_free_i,
  output logic              take_o,
  output logic              res_valid_o,
  output u7d_pkg::result_t  res_o
);

  u7d_pkg::mode_e mode_q, mode_d;
  logic [20:0]    buf_q, buf_d;
  logic [4:0]     cnt_q, cnt_d;
  logic [9:0]     hs_q, hs_d;
  logic           pend_q, pend_d;

  logic [6:0]     b64;
  logic [7:0]     b;
  logic           do_close, do_direct, do_push;
  logic           flag_byte, flag_surr;
  logic [20:0]    cp;
  logic           has;
  logic [20:0]    nbuf;
  logic [4:0]     ncnt, rem;
  logic [20:0]    shifted;
  logic [15:0]    unit;
  logic           produce;

  assign b   = item_i.in_byte;
  assign b64 = u7d_pkg::b64_lookup(b);

  // Next state and result for the held byte
  always_comb begin
    mode_d    = mode_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    hs_d      = hs_q;
    pend_d    = pend_q;
    do_close  = 1'b0;
    do_direct = 1'b0;
    do_push   = 1'b0;
    flag_byte = 1'b0;
    flag_surr = 1'b0;
    cp        = 21'd0;
    has       = 1'b0;
    nbuf      = 21'd0;
    ncnt      = 5'd0;
    rem       = 5'd0;
    shifted   = 21'd0;
    unit      = 16'd0;

    // mode dispatch
    case (mode_q)
      u7d_pkg::MODE_B64: begin
        if (b64[6]) begin
          do_push = 1'b1;
        end else if (b == u7d_pkg::CH_MINUS) begin
          do_close = 1'b1;
        end else begin
          do_close  = 1'b1;
          do_direct = 1'b1;
        end
      end
      u7d_pkg::MODE_PLUS: begin
        if (b == u7d_pkg::CH_MINUS) begin
          cp     = {13'd0, u7d_pkg::CH_PLUS};
          has    = 1'b1;
          mode_d = u7d_pkg::MODE_DIRECT;
        end else if (b64[6]) begin
          mode_d  = u7d_pkg::MODE_B64;
          do_push = 1'b1;
        end else begin
          flag_byte = 1'b1;
          mode_d    = u7d_pkg::MODE_DIRECT;
          do_direct = 1'b1;
        end
      end
      default: begin
        mode_d    = u7d_pkg::MODE_DIRECT;
        do_direct = 1'b1;
      end
    endcase

    // close a base64 run; leftover bits are dropped
    if (do_close) begin
      if (pend_q) flag_surr = 1'b1;
      pend_d = 1'b0;
      hs_d   = 10'd0;
      buf_d  = 21'd0;
      cnt_d  = 5'd0;
      mode_d = u7d_pkg::MODE_DIRECT;
    end

    // direct byte handling
    if (do_direct) begin
      if (b == u7d_pkg::CH_PLUS) begin
        mode_d = u7d_pkg::MODE_PLUS;
      end else if (u7d_pkg::is_direct(b)) begin
        cp  = {13'd0, b};
        has = 1'b1;
      end else begin
        flag_byte = 1'b1;
      end
    end

    // append six bits, pull out a UTF-16 unit when one is complete
    if (do_push) begin
      nbuf  = {buf_q[14:0], b64[5:0]};
      ncnt  = cnt_q + u7d_pkg::B64_BITS;
      buf_d = nbuf;
      cnt_d = ncnt;
      if (ncnt >= u7d_pkg::UNIT_BITS) begin
        rem     = ncnt - u7d_pkg::UNIT_BITS;
        shifted = nbuf >> rem;
        unit    = shifted[15:0];
        buf_d   = nbuf & ((21'd1 << rem) - 21'd1);
        cnt_d   = rem;
        if (unit[15:10] == 6'b110110) begin
          // high surrogate
          if (pend_q) flag_surr = 1'b1;
          hs_d   = unit[9:0];
          pend_d = 1'b1;
        end else if (unit[15:10] == 6'b110111) begin
          // low surrogate
          if (pend_q) begin
            cp  = u7d_pkg::SUPP_BASE + {1'b0, hs_q, unit[9:0]};
            has = 1'b1;
          end else begin
            flag_surr = 1'b1;
          end
          pend_d = 1'b0;
          hs_d   = 10'd0;
        end else begin
          if (pend_q) flag_surr = 1'b1;
          pend_d = 1'b0;
          hs_d   = 10'd0;
          cp     = {5'd0, unit};
          has    = 1'b1;
        end
      end
    end

    // end of string: flush and return to reset state
    if (item_i.is_last) begin
      if (pend_d) flag_surr = 1'b1;
      if (mode_d == u7d_pkg::MODE_PLUS) flag_byte = 1'b1;
      mode_d = u7d_pkg::MODE_DIRECT;
      buf_d  = 21'd0;
      cnt_d  = 5'd0;
      hs_d   = 10'd0;
      pend_d = 1'b0;
    end
  end

  assign produce = has || flag_byte || flag_surr || item_i.is_last;

  // An item without a result never waits on the output side
  assign take_o      = item_valid_i && (!produce || out_free_i);
  assign res_valid_o = take_o && produce;

  assign res_o.char_val   = cp;
  assign res_o.has_char   = has;
  assign res_o.error_kind = flag_surr ? u7d_pkg::ERR_SURR :
                            flag_byte ? u7d_pkg::ERR_BYTE : u7d_pkg::ERR_NONE;
  assign res_o.stream_end = item_i.is_last;

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= u7d_pkg::MODE_DIRECT;
      buf_q  <= 21'd0;
      cnt_q  <= 5'd0;
      hs_q   <= 10'd0;
      pend_q <= 1'b0;
    end else if (take_o) begin
      mode_q <= mode_d;
      buf_q  <= buf_d;
      cnt_q  <= cnt_d;
      hs_q   <= hs_d;
      pend_q <= pend_d;
    end
  end

endmodule

@@ design/u7d_out_reg.sv @@
module u7d_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  u7d_pkg::result_t  res_i,
  output logic              out_free_o,
  u7d_cp_if.source          cp_o
);

  logic             valid_q;
  u7d_pkg::result_t res_q;

  assign out_free_o = !valid_q || cp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (cp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign cp_o.valid      = valid_q;
  assign cp_o.char_val   = res_q.char_val;
  assign cp_o.has_char   = res_q.has_char;
  assign cp_o.error_kind = res_q.error_kind;
  assign cp_o.stream_end = res_q.stream_end;

endmodule

@@ design/utf7_stream_decoder_top.sv @@
// UTF-7 stream decoder: one byte request in per cycle on byte_i, at most one
// result request out per byte on cp_o (code point, error kind, end mark).
// A byte lands in an input register, is decoded against the run state in one
// pass, and its result is loaded into an output register. Bytes that give no
// result (a plus, a minus closing a run with no high surrogate pending,
// base64 characters that do not finish a unit) never wait on cp_o. Sustained
// rate is one byte per cycle while cp_o takes results; a stalled result stops
// the input only once a byte that needs an output slot reaches the decode
// stage. The is_last byte always gives a result with stream_end set and
// returns the decoder to its reset state.
module utf7_stream_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  u7d_byte_if.sink   byte_i,
  u7d_cp_if.source   cp_o
);

  logic             item_valid;
  u7d_pkg::item_t   item;
  logic             take;
  logic             out_free;
  logic             res_valid;
  u7d_pkg::result_t res;

  u7d_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  u7d_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .out_free_i   (out_free),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  u7d_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .out_free_o (out_free),
    .cp_o       (cp_o)
  );

  // Code point field is zero unless it carries a character
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_o.valid && !cp_o.has_char |-> cp_o.char_val == 21'd0)
    else $error("code point set without a character flag");

  // Decoded values stay within the Unicode range
  a_cp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_o.valid && cp_o.has_char |-> cp_o.char_val <= u7d_pkg::CP_MAX)
    else $error("code point out of range");

  // A last byte always needs an output slot: with the output stalled it blocks input
  a_last_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_o.valid && !cp_o.ready && item_valid && item.is_last |-> !byte_i.ready)
    else $error("input taken while last byte waits on a stalled output");

  // Every loaded result is either an end mark, a character or an error
  a_res_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res.stream_end || res.has_char ||
                  res.error_kind != u7d_pkg::ERR_NONE)
    else $error("empty result loaded");

endmodule
